[rtl/arp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and constants of the note arpeggiator: transfer payloads,
// operation and pattern codes, register indexes, controller to datapath
// command and status groups.
// ----------------------------------------------------------------------------
package arp_pkg;

    // input operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_ON      = 2'd1;
    localparam logic [1:0] OP_OFF     = 2'd2;
    localparam logic [1:0] OP_ALL_OFF = 2'd3;

    // pattern modes
    localparam logic [1:0] MODE_UP     = 2'd0;
    localparam logic [1:0] MODE_DOWN   = 2'd1;
    localparam logic [1:0] MODE_UPDOWN = 2'd2;
    localparam logic [1:0] MODE_RANDOM = 2'd3;

    // configuration register indexes
    localparam int         CFG_AW          = 3;
    localparam int         CFG_DW          = 32;
    localparam logic [2:0] CFG_ENABLED     = 3'd0;
    localparam logic [2:0] CFG_PATTERN     = 3'd1;
    localparam logic [2:0] CFG_STEP        = 3'd2;
    localparam logic [2:0] CFG_GATE        = 3'd3;
    localparam logic [2:0] CFG_SEED        = 3'd4;

    // register reset values and limits
    localparam logic [19:0] STEP_RESET = 20'd5513;
    localparam logic [8:0]  GATE_RESET = 9'd205;
    localparam logic [8:0]  GATE_MIN   = 9'd26;
    localparam logic [8:0]  GATE_MAX   = 9'd256;
    localparam logic [31:0] SEED_RESET = 32'd1;
    localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;

    // input item
    typedef struct packed {
        logic [1:0] op;
        logic [6:0] note;
    } t_item;

    // result item
    typedef struct packed {
        logic       is_note_on;
        logic [6:0] note_number;
        logic       last;
    } t_result;

    // controller commands
    typedef struct packed {
        logic load;
        logic hold;
        logic tick;
        logic pick;
        logic fire;
    } t_cmd;

    // datapath status
    typedef struct packed {
        logic enabled;
        logic step_now;
        logic random;
        logic div_done;
    } t_stat;

endpackage

[rtl/arp_modu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_modu
// Bit-serial modulo unit: remainder of a 32-bit value by the held count,
// one restoring step per cycle over the 32 dividend bits, then a done pulse.
// ----------------------------------------------------------------------------
module arp_modu #(
    parameter int MAX_HELD = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [31:0]                     i_dividend,
    input  logic [$clog2(MAX_HELD+1)-1:0]   i_divisor,
    output logic                            o_done,
    output logic [$clog2(MAX_HELD)-1:0]     o_rem
);

    localparam int CW = $clog2(MAX_HELD + 1);
    localparam int IW = $clog2(MAX_HELD);

    logic [31:0]   r_dvd, n_dvd;
    logic [CW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_div, n_div;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW:0]   trial;
    logic [CW:0]   diff;

    // one restoring step
    assign trial = {r_rem, r_dvd[31]};
    assign diff  = trial - {1'b0, r_div};

    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd = {r_dvd[30:0], 1'b0};
            n_rem = (trial >= {1'b0, r_div}) ? diff[CW-1:0] : trial[CW-1:0];
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[IW-1:0];

`ifndef SYNTHESIS
    // remainder is a valid index into the held set
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("modulo remainder not below divisor");
`endif

endmodule

[rtl/arp_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_dp
// Arpeggiator datapath: configuration registers, sorted held-note row,
// pattern position, step and gate timers, gate length multiplier, LFSR and
// result register.
// ----------------------------------------------------------------------------
module arp_dp #(
    parameter int MAX_HELD = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  arp_pkg::t_cmd                i_cmd,
    output arp_pkg::t_stat               o_stat,
    input  arp_pkg::t_item               i_item,
    input  logic                         i_cfg_we,
    input  logic [arp_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [arp_pkg::CFG_DW-1:0]   i_cfg_data,
    output arp_pkg::t_result             o_result,
    output logic                         o_valid
);

    localparam int CW = $clog2(MAX_HELD + 1);
    localparam int IW = $clog2(MAX_HELD);
    localparam int PW = $clog2(2 * MAX_HELD - 1);

    // configuration
    logic          r_en, n_en;
    logic [1:0]    r_mode, n_mode;
    logic [19:0]   r_step_cfg, n_step_cfg;
    logic [8:0]    r_gate_cfg, n_gate_cfg;
    logic [31:0]   r_lfsr, n_lfsr;
    // item and arpeggio state
    logic [1:0]    r_op, n_op;
    logic [6:0]    r_note, n_note;
    logic [6:0]    r_held [MAX_HELD];
    logic [6:0]    n_held [MAX_HELD];
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_pos, n_pos;
    logic [19:0]   r_step_cnt, n_step_cnt;
    logic [19:0]   r_gate_cnt, n_gate_cnt;
    logic          r_play_v, n_play_v;
    logic [6:0]    r_play_note, n_play_note;
    logic [28:0]   r_prod, n_prod;
    logic [IW-1:0] r_idx, n_idx;
    arp_pkg::t_result r_res, n_res;
    logic          r_res_valid, n_res_valid;

    logic [MAX_HELD-1:0] gt, eq;
    logic [6:0]    ins_held [MAX_HELD];
    logic [6:0]    del_held [MAX_HELD];
    logic          dup;
    logic [CW-1:0] cnt_up, cnt_dn;
    logic [PW-1:0] len_cur;
    logic [PW:0]   n_ext, p_ext, idx_full, pos_inc;
    logic [PW-1:0] pos_next;
    logic [19:0]   step_eff;
    logic [8:0]    gate_clamp;
    logic [28:0]   gate_sum;
    logic [19:0]   gate_len;
    logic [31:0]   lfsr_adv;
    logic          step_now;
    logic          off_now;
    logic          mod_start;
    logic          mod_done;
    logic [IW-1:0] mod_rem;

    // pattern length for a mode and a held count
    function automatic logic [PW-1:0] f_len(input logic [1:0] mode,
                                            input logic [CW-1:0] cnt);
        logic [PW:0] dbl;
        dbl = {{(PW + 1 - CW){1'b0}}, cnt} << 1;
        if (mode == arp_pkg::MODE_UPDOWN && cnt > CW'(2)) begin
            return PW'(dbl - (PW + 1)'(2));
        end
        return PW'(cnt);
    endfunction

    // per-entry compare against the item note
    always_comb begin
        for (int j = 0; j < MAX_HELD; j++) begin
            gt[j] = (CW'(j) < r_count) && (r_held[j] > r_note);
            eq[j] = (CW'(j) < r_count) && (r_held[j] == r_note);
        end
    end
    assign dup = |eq;

    // row after an insertion: greater entries move up one place
    always_comb begin
        ins_held[0] = (gt[0] || r_count == '0) ? r_note : r_held[0];
        for (int j = 1; j < MAX_HELD; j++) begin
            if (gt[j-1]) begin
                ins_held[j] = r_held[j-1];
            end else if (gt[j] || CW'(j) == r_count) begin
                ins_held[j] = r_note;
            end else begin
                ins_held[j] = r_held[j];
            end
        end
    end

    // row after a removal: matching and greater entries move down one place
    always_comb begin
        for (int j = 0; j < MAX_HELD - 1; j++) begin
            del_held[j] = (gt[j] || eq[j]) ? r_held[j+1] : r_held[j];
        end
        del_held[MAX_HELD-1] = r_held[MAX_HELD-1];
    end

    assign cnt_up  = r_count + CW'(1);
    assign cnt_dn  = r_count - CW'(1);
    assign len_cur = f_len(r_mode, r_count);

    // pattern index and next position
    assign n_ext = {{(PW + 1 - CW){1'b0}}, r_count};
    assign p_ext = {1'b0, r_pos};
    always_comb begin
        case (r_mode)
            arp_pkg::MODE_DOWN: idx_full = n_ext - p_ext - (PW + 1)'(1);
            arp_pkg::MODE_UPDOWN: begin
                if (p_ext >= n_ext) begin
                    idx_full = (n_ext << 1) - (PW + 1)'(2) - p_ext;
                end else begin
                    idx_full = p_ext;
                end
            end
            default: idx_full = p_ext;
        endcase
    end
    assign pos_inc  = p_ext + (PW + 1)'(1);
    assign pos_next = (pos_inc == {1'b0, len_cur}) ? '0 : pos_inc[PW-1:0];

    // step length, gate clamp and rounded gate length
    assign step_eff   = (r_step_cfg == '0) ? 20'd1 : r_step_cfg;
    assign gate_clamp = (r_gate_cfg < arp_pkg::GATE_MIN) ? arp_pkg::GATE_MIN :
                        (r_gate_cfg > arp_pkg::GATE_MAX) ? arp_pkg::GATE_MAX : r_gate_cfg;
    assign gate_sum   = r_prod + 29'd128;
    assign gate_len   = (gate_sum[27:8] == '0) ? 20'd1 : gate_sum[27:8];

    // galois lfsr, one shift per random pick
    assign lfsr_adv = r_lfsr[0] ? ((r_lfsr >> 1) ^ arp_pkg::LFSR_TAPS) : (r_lfsr >> 1);

    assign step_now = (r_step_cnt == '0) && (r_count != '0);
    assign off_now  = r_play_v && (r_gate_cnt == 20'd1 || step_now);

    // modulo unit for random picks
    arp_modu #(
        .MAX_HELD (MAX_HELD)
    ) u_modu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (lfsr_adv),
        .i_divisor  (r_count),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // next-state logic
    always_comb begin
        n_en        = r_en;
        n_mode      = r_mode;
        n_step_cfg  = r_step_cfg;
        n_gate_cfg  = r_gate_cfg;
        n_lfsr      = r_lfsr;
        n_op        = r_op;
        n_note      = r_note;
        n_held      = r_held;
        n_count     = r_count;
        n_pos       = r_pos;
        n_step_cnt  = r_step_cnt;
        n_gate_cnt  = r_gate_cnt;
        n_play_v    = r_play_v;
        n_play_note = r_play_note;
        n_prod      = r_prod;
        n_idx       = r_idx;
        n_res       = r_res;
        n_res_valid = 1'b0;
        mod_start   = 1'b0;

        // latch the accepted item
        if (i_cmd.load) begin
            n_op   = i_item.op;
            n_note = i_item.note;
        end

        // held set update
        if (i_cmd.hold) begin
            case (r_op)
                arp_pkg::OP_ON: begin
                    if (!dup && r_count < CW'(MAX_HELD)) begin
                        n_held  = ins_held;
                        n_count = cnt_up;
                        n_pos   = (r_pos >= f_len(r_mode, cnt_up)) ? '0 : r_pos;
                    end
                end
                arp_pkg::OP_OFF: begin
                    if (dup) begin
                        n_held  = del_held;
                        n_count = cnt_dn;
                        n_pos   = (r_pos >= f_len(r_mode, cnt_dn)) ? '0 : r_pos;
                    end
                end
                arp_pkg::OP_ALL_OFF: begin
                    n_count = '0;
                    n_pos   = '0;
                end
                default: ;
            endcase
        end

        // gate and step timers, note-off of the sounding note
        if (i_cmd.tick) begin
            if (r_gate_cnt != '0) begin
                n_gate_cnt = r_gate_cnt - 20'd1;
            end
            if (off_now) begin
                n_res.is_note_on  = 1'b0;
                n_res.note_number = r_play_note;
                n_res.last        = !step_now;
                n_res_valid       = 1'b1;
                n_play_v          = 1'b0;
            end
            n_step_cnt = ((r_step_cnt == '0) ? step_eff : r_step_cnt) - 20'd1;
        end

        // gate length product and next pattern index
        if (i_cmd.pick) begin
            n_prod = 29'(step_eff) * 29'(gate_clamp);
            if (r_mode == arp_pkg::MODE_RANDOM) begin
                n_lfsr    = lfsr_adv;
                mod_start = 1'b1;
            end else begin
                n_idx = idx_full[IW-1:0];
                n_pos = pos_next;
            end
        end

        if (mod_done) begin
            n_idx = mod_rem;
        end

        // note-on of the picked note
        if (i_cmd.fire) begin
            n_play_note       = r_held[r_idx];
            n_play_v          = 1'b1;
            n_gate_cnt        = gate_len;
            n_res.is_note_on  = 1'b1;
            n_res.note_number = r_held[r_idx];
            n_res.last        = 1'b1;
            n_res_valid       = 1'b1;
        end

        // configuration writes
        if (i_cfg_we) begin
            case (i_cfg_addr)
                arp_pkg::CFG_ENABLED: begin
                    n_en = i_cfg_data[0];
                    if (!i_cfg_data[0]) begin
                        n_count     = '0;
                        n_pos       = '0;
                        n_step_cnt  = '0;
                        n_gate_cnt  = '0;
                        n_play_v    = 1'b0;
                        n_play_note = '0;
                    end
                end
                arp_pkg::CFG_PATTERN: begin
                    n_mode = i_cfg_data[1:0];
                    n_pos  = (r_pos >= f_len(i_cfg_data[1:0], r_count)) ? '0 : r_pos;
                end
                arp_pkg::CFG_STEP: n_step_cfg = i_cfg_data[19:0];
                arp_pkg::CFG_GATE: n_gate_cfg = i_cfg_data[8:0];
                arp_pkg::CFG_SEED: n_lfsr     = i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= 1'b1;
            r_mode      <= arp_pkg::MODE_UP;
            r_step_cfg  <= arp_pkg::STEP_RESET;
            r_gate_cfg  <= arp_pkg::GATE_RESET;
            r_lfsr      <= arp_pkg::SEED_RESET;
            r_count     <= '0;
            r_pos       <= '0;
            r_step_cnt  <= '0;
            r_gate_cnt  <= '0;
            r_play_v    <= 1'b0;
            r_play_note <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_en        <= n_en;
            r_mode      <= n_mode;
            r_step_cfg  <= n_step_cfg;
            r_gate_cfg  <= n_gate_cfg;
            r_lfsr      <= n_lfsr;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_step_cnt  <= n_step_cnt;
            r_gate_cnt  <= n_gate_cnt;
            r_play_v    <= n_play_v;
            r_play_note <= n_play_note;
            r_res_valid <= n_res_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_note <= n_note;
        r_held <= n_held;
        r_prod <= n_prod;
        r_idx  <= n_idx;
        r_res  <= n_res;
    end

    assign o_stat.enabled  = r_en;
    assign o_stat.step_now = step_now;
    assign o_stat.random   = (r_mode == arp_pkg::MODE_RANDOM);
    assign o_stat.div_done = mod_done;
    assign o_result        = r_res;
    assign o_valid         = r_res_valid;

`ifndef SYNTHESIS
    // held set never exceeds its capacity
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_HELD))
        else $error("held count above capacity");

    // position stays inside the pattern
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_pos < len_cur))
        else $error("pattern position out of range");

    // empty set keeps the position at the start
    a_pos_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_pos == '0))
        else $error("position nonzero with empty set");

    // a note-on always closes its tick
    a_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.is_note_on) |-> r_res.last)
        else $error("note-on not marked last");
`endif

endmodule

[rtl/arp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_ctrl
// Arpeggiator controller: sequences a held-set update or the tick steps
// (timers, gate product and pick, optional modulo wait, note-on).
// ----------------------------------------------------------------------------
module arp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_op,
    input  arp_pkg::t_stat  i_stat,
    output arp_pkg::t_cmd   o_cmd,
    output logic            o_busy
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_NOTE = 6'b000010,
        S_TICK = 6'b000100,
        S_PICK = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIRE = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // state transitions
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_op == arp_pkg::OP_TICK) ? S_TICK : S_NOTE;
                end
            end
            S_NOTE: n_state = S_IDLE;
            S_TICK: n_state = (i_stat.enabled && i_stat.step_now) ? S_PICK : S_IDLE;
            S_PICK: n_state = i_stat.random ? S_DIV : S_FIRE;
            S_DIV:  n_state = i_stat.div_done ? S_FIRE : S_DIV;
            S_FIRE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands to the datapath
    assign o_cmd.load = (r_state == S_IDLE) && i_start;
    assign o_cmd.hold = (r_state == S_NOTE);
    assign o_cmd.tick = (r_state == S_TICK) && i_stat.enabled;
    assign o_cmd.pick = (r_state == S_PICK);
    assign o_cmd.fire = (r_state == S_FIRE);
    assign o_busy     = (r_state != S_IDLE);

endmodule

[rtl/note_arpeggiator.sv]
`timescale 1ns / 1ps
// A note on/off/all-off item keeps busy high for 1 cycle after the transfer.
// A tick without a step keeps busy 1 cycle; a note-off is registered in the tick state.
// A step in up, down or up-down keeps busy through the tick, pick and fire states.
// The note-on is registered in fire; random mode also waits in divide for the modulo unit.
// Results cannot be stalled; reset is synchronous active low and leaves the block idle
// with an empty held set and registers at their defaults.
// ----------------------------------------------------------------------------
// note_arpeggiator
// Arpeggiator top level: controller and datapath, command-style item port,
// strobed result port and register write port.
// ----------------------------------------------------------------------------
module note_arpeggiator #(
    parameter int MAX_HELD = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  arp_pkg::t_item               i_item,
    output arp_pkg::t_result             o_result,
    output logic                         o_valid,
    input  logic                         i_cfg_we,
    input  logic [arp_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [arp_pkg::CFG_DW-1:0]   i_cfg_data
);

    arp_pkg::t_cmd  cmd;
    arp_pkg::t_stat stat;

    // sequencer
    arp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_item.op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // held set, timers and result register
    arp_dp #(
        .MAX_HELD (MAX_HELD)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result),
        .o_valid    (o_valid)
    );

endmodule

[test/tb_note_arpeggiator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_note_arpeggiator
// Self-checking bench for the note arpeggiator. A driver pushes note and tick
// commands from a queue, with random bursts of idle cycles. A predictor keeps
// its own copy of the held set, the timers, the pattern position and the LFSR,
// and works out the note-on/note-off events that each tick should produce. A
// monitor compares every strobed event with the oldest predicted one. The run
// starts with a short directed part, then goes through many register settings
// with random note and tick traffic.
// ----------------------------------------------------------------------------
module tb_note_arpeggiator;
    import arp_pkg::*;

    localparam int MAX_HELD     = 16;
    localparam int HW           = $clog2(MAX_HELD);
    localparam int DRAIN_CYCLES = 48;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1750;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                start      = 1'b0;
    logic                busy;
    t_item               i_item     = '0;
    t_result             o_result;
    logic                o_valid;
    logic                i_cfg_we   = 1'b0;
    logic [CFG_AW-1:0]   i_cfg_addr = '0;
    logic [CFG_DW-1:0]   i_cfg_data = '0;

    // pending commands and predicted events
    t_item       stim_q [$];
    t_result     due_events [$];

    // predictor copy of the registers
    bit          arp_enabled;
    logic [1:0]  arp_mode;
    logic [19:0] arp_step;
    logic [8:0]  arp_gate;

    // predictor copy of the state
    logic [6:0]  held_notes [MAX_HELD];
    int unsigned held_n;
    int unsigned arp_pos;
    int unsigned step_left;
    int unsigned gate_left;
    bit          sounding;
    logic [6:0]  sounding_note;
    logic [31:0] lfsr;

    // run bookkeeping
    bit          gaps_on = 1'b1;
    int          gap_left = 0;
    int          items_sent = 0;
    int          ticks_sent = 0;
    int          events_checked = 0;
    int          mismatches = 0;
    int          settings_used = 0;
    int          cycles = 0;

    note_arpeggiator #(
        .MAX_HELD   (MAX_HELD)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_result   (o_result),
        .o_valid    (o_valid),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events still due", cycles,
                     due_events.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic int unsigned arp_length();
        if (arp_mode == MODE_UPDOWN && held_n > 2)
            return 2 * held_n - 2;
        return held_n;
    endfunction

    // keep the position inside the pattern after a set or mode change
    function automatic void arp_refresh();
        if (held_n == 0)
            arp_pos = 0;
        else if (arp_pos >= arp_length())
            arp_pos = 0;
    endfunction

    function automatic int unsigned arp_index(int unsigned p);
        int unsigned idx;
        if (arp_mode == MODE_DOWN)
            idx = held_n - 1 - p;
        else if (arp_mode == MODE_UPDOWN && p >= held_n)
            idx = 2 * held_n - 2 - p;
        else
            idx = p;
        if (idx >= MAX_HELD)
            idx = 0;
        return idx;
    endfunction

    function automatic void arp_clear();
        held_n        = 0;
        arp_pos       = 0;
        step_left     = 0;
        gate_left     = 0;
        sounding      = 1'b0;
        sounding_note = '0;
    endfunction

    // sorted insert, duplicates and overflow dropped
    function automatic void held_insert(logic [6:0] n);
        int unsigned i;
        int unsigned j;
        i = 0;
        while (i < held_n && held_notes[HW'(i)] < n)
            i++;
        if (i < held_n && held_notes[HW'(i)] == n)
            return;
        if (held_n >= MAX_HELD)
            return;
        for (j = held_n; j > i; j--)
            held_notes[HW'(j)] = held_notes[HW'(j - 1)];
        held_notes[HW'(i)] = n;
        held_n++;
        arp_refresh();
    endfunction

    function automatic void held_remove(logic [6:0] n);
        int unsigned i;
        int unsigned j;
        for (i = 0; i < held_n; i++) begin
            if (held_notes[HW'(i)] == n) begin
                for (j = i; j + 1 < held_n; j++)
                    held_notes[HW'(j)] = held_notes[HW'(j + 1)];
                held_n--;
                arp_refresh();
                return;
            end
        end
    endfunction

    function automatic t_result note_event(bit on, logic [6:0] n);
        t_result r;
        r.is_note_on  = on;
        r.note_number = n;
        r.last        = 1'b0;
        return r;
    endfunction

    // one sample tick: gate timer, then step timer
    function automatic void arp_tick();
        t_result     ev [2];
        int          k;
        int unsigned stepv;
        int unsigned g;
        int unsigned gs;
        logic [31:0] s;
        logic [6:0]  nxt;
        k = 0;
        if (gate_left > 0) begin
            gate_left--;
            if (gate_left == 0 && sounding) begin
                ev[1'(k)] = note_event(1'b0, sounding_note);
                k++;
                sounding = 1'b0;
            end
        end
        if (step_left == 0) begin
            stepv = (arp_step == '0) ? 1 : 32'(arp_step);
            step_left = stepv;
            if (held_n > 0) begin
                g = 32'(arp_gate);
                if (g < GATE_MIN)
                    g = 32'(GATE_MIN);
                if (g > GATE_MAX)
                    g = 32'(GATE_MAX);
                gs = (stepv * g + 128) >> 8;
                if (gs < 1)
                    gs = 1;
                if (sounding) begin
                    ev[1'(k)] = note_event(1'b0, sounding_note);
                    k++;
                    sounding = 1'b0;
                end
                if (arp_mode == MODE_RANDOM) begin
                    s = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
                    lfsr = s;
                    nxt = held_notes[HW'(s % held_n)];
                end else begin
                    nxt = held_notes[HW'(arp_index(arp_pos))];
                    arp_pos = (arp_pos + 1) % arp_length();
                end
                sounding_note = nxt;
                sounding = 1'b1;
                ev[1'(k)] = note_event(1'b1, nxt);
                k++;
                gate_left = gs;
            end
        end
        step_left--;
        if (k > 0)
            ev[1'(k - 1)].last = 1'b1;
        for (int i = 0; i < k; i++)
            due_events = {due_events, ev[1'(i)]};
    endfunction

    function automatic void arp_apply(t_item it);
        case (it.op)
            OP_ON: held_insert(it.note);
            OP_OFF: held_remove(it.note);
            OP_ALL_OFF: begin
                held_n  = 0;
                arp_pos = 0;
            end
            default: begin
                if (arp_enabled)
                    arp_tick();
            end
        endcase
    endfunction

    function automatic void arp_set_register(logic [2:0] addr, logic [31:0] data);
        case (addr)
            CFG_ENABLED: begin
                arp_enabled = data[0];
                if (!arp_enabled)
                    arp_clear();
            end
            CFG_PATTERN: begin
                arp_mode = data[1:0];
                arp_refresh();
            end
            CFG_STEP: arp_step = data[19:0];
            CFG_GATE: arp_gate = data[8:0];
            CFG_SEED: lfsr = data;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // driver: one command per transfer, random idle bursts
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                arp_apply(i_item);
                items_sent++;
                if (i_item.op == OP_TICK)
                    ticks_sent++;
            end
            if (start && busy) begin
                // hold the command until the transfer
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (stim_q.size() > 0) begin
                if (gaps_on && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 5) - 1;
                    start <= 1'b0;
                end else begin
                    start  <= 1'b1;
                    i_item <= stim_q.pop_front();
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: every strobed event against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (due_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event: on=%0d note=%0d last=%0d",
                             o_result.is_note_on, o_result.note_number, o_result.last);
            end else begin
                want = due_events.pop_front();
                events_checked++;
                if (o_result.is_note_on !== want.is_note_on ||
                    o_result.note_number !== want.note_number ||
                    o_result.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"event %0d mismatch: expected on=%0d note=%0d last=%0d,",
                                  " got on=%0d note=%0d last=%0d"},
                                 events_checked, want.is_note_on, want.note_number,
                                 want.last, o_result.is_note_on, o_result.note_number,
                                 o_result.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        arp_set_register(addr, data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic push_item(logic [1:0] op, logic [6:0] n);
        t_item it;
        it.op   = op;
        it.note = n;
        stim_q = {stim_q, it};
    endtask

    // sender pauses until every predicted event is back and the block is idle
    task automatic wait_quiet();
        while (stim_q.size() != 0 || start || due_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        settings_used++;
    endtask

    initial begin
        int          random_items;
        int          ph;
        int          n;
        int          burst;
        int          r;
        int          pick;
        int          pool_base;
        bit          quiet;
        logic [19:0] stepv;
        logic [8:0]  gatev;
        logic [31:0] seedv;

        // predictor starts from the reset state
        arp_enabled = 1'b1;
        arp_mode    = MODE_UP;
        arp_step    = STEP_RESET;
        arp_gate    = GATE_RESET;
        lfsr        = SEED_RESET;
        arp_clear();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: extremes of the note range, duplicate, unknown note-off
        push_item(OP_ON, 7'd0);
        push_item(OP_ON, 7'd127);
        push_item(OP_ON, 7'd0);
        push_item(OP_OFF, 7'd64);
        push_item(OP_TICK, 7'd0);
        push_item(OP_ALL_OFF, 7'd0);
        push_item(OP_TICK, 7'd127);
        wait_quiet();

        // zero step and gate below range, up pattern
        cfg_write(CFG_ENABLED, 32'd0);
        cfg_write(CFG_ENABLED, 32'd1);
        cfg_write(CFG_STEP, 32'd0);
        cfg_write(CFG_GATE, 32'd0);
        cfg_write(CFG_PATTERN, 32'(MODE_UP));
        push_item(OP_ON, 7'd64);
        push_item(OP_ON, 7'd60);
        push_item(OP_ON, 7'd62);
        repeat (3) push_item(OP_TICK, 7'd0);
        wait_quiet();

        // down pattern, gate above range
        cfg_write(CFG_PATTERN, 32'(MODE_DOWN));
        cfg_write(CFG_STEP, 32'd2);
        cfg_write(CFG_GATE, 32'd511);
        repeat (2) push_item(OP_TICK, 7'd0);
        push_item(OP_OFF, 7'd62);
        push_item(OP_TICK, 7'd0);
        wait_quiet();

        // notes change the held set while disabled, ticks ignored
        cfg_write(CFG_ENABLED, 32'd0);
        push_item(OP_ON, 7'd10);
        push_item(OP_ON, 7'd20);
        push_item(OP_OFF, 7'd10);
        push_item(OP_TICK, 7'd0);
        wait_quiet();

        // up-down with full gate
        cfg_write(CFG_ENABLED, 32'd1);
        cfg_write(CFG_PATTERN, 32'(MODE_UPDOWN));
        cfg_write(CFG_STEP, 32'd1);
        cfg_write(CFG_GATE, 32'd256);
        push_item(OP_ON, 7'd30);
        push_item(OP_ON, 7'd40);
        repeat (3) push_item(OP_TICK, 7'd0);
        wait_quiet();

        // random mode with a stuck zero seed, then an all-ones seed
        cfg_write(CFG_PATTERN, 32'(MODE_RANDOM));
        cfg_write(CFG_SEED, 32'd0);
        repeat (2) push_item(OP_TICK, 7'd0);
        wait_quiet();
        cfg_write(CFG_SEED, 32'hFFFF_FFFF);
        repeat (2) push_item(OP_TICK, 7'd0);
        wait_quiet();

        // longest step
        cfg_write(CFG_STEP, 32'hF_FFFF);
        cfg_write(CFG_GATE, 32'd26);
        repeat (2) push_item(OP_TICK, 7'd0);
        wait_quiet();

        // random traffic across many register settings
        random_items = 0;
        for (ph = 0; random_items < RANDOM_ITEMS; ph++) begin
            gaps_on = (random_items < RANDOM_ITEMS - 300) && (ph % 3 != 2);
            quiet   = (ph % 9 == 4);

            // a write of zero also restarts a long step countdown
            if (quiet || !arp_enabled || step_left > 64 || $urandom_range(0, 4) == 0)
                cfg_write(CFG_ENABLED, 32'd0);
            if (!quiet)
                cfg_write(CFG_ENABLED, 32'd1);
            cfg_write(CFG_PATTERN, $urandom_range(0, 3));

            pick = $urandom_range(0, 19);
            if (pick == 0)
                stepv = 20'hF_FFFF;
            else if (pick == 1)
                stepv = 20'd0;
            else if (pick < 6)
                stepv = 20'($urandom_range(7, 40));
            else
                stepv = 20'($urandom_range(1, 6));
            cfg_write(CFG_STEP, 32'(stepv));

            pick = $urandom_range(0, 9);
            if (pick == 0)
                gatev = 9'($urandom_range(0, 25));
            else if (pick == 1)
                gatev = 9'($urandom_range(257, 511));
            else if (pick == 2)
                gatev = GATE_MIN;
            else if (pick == 3)
                gatev = GATE_MAX;
            else
                gatev = 9'($urandom_range(26, 256));
            cfg_write(CFG_GATE, 32'(gatev));

            if ($urandom_range(0, 2) == 0) begin
                pick = $urandom_range(0, 5);
                if (pick == 0)
                    seedv = 32'd0;
                else if (pick == 1)
                    seedv = 32'hFFFF_FFFF;
                else
                    seedv = $urandom;
                cfg_write(CFG_SEED, seedv);
            end

            // a pool of twenty notes so that sets fill up and note-offs hit
            pool_base = $urandom_range(0, 108);
            burst = $urandom_range(1, 18);
            for (int i = 0; i < burst; i++)
                push_item(OP_ON, 7'(pool_base + $urandom_range(0, 19)));

            if (quiet)
                n = 20;
            else if (stepv == 20'hF_FFFF)
                n = 12;
            else
                n = $urandom_range(100, 200);
            for (int i = 0; i < n; i++) begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    push_item(OP_TICK, 7'($urandom_range(0, 127)));
                else if (r < 78)
                    push_item(OP_ON, 7'(pool_base + $urandom_range(0, 19)));
                else if (r < 94)
                    push_item(OP_OFF, 7'(pool_base + $urandom_range(0, 19)));
                else if (r < 96)
                    push_item(OP_ALL_OFF, 7'($urandom_range(0, 127)));
                else
                    push_item(2'($urandom_range(1, 2)), 7'($urandom_range(0, 127)));
            end
            if (!quiet)
                random_items += n + burst;
            wait_quiet();
        end

        if (due_events.size() != 0) begin
            $display("%0d predicted events never arrived", due_events.size());
            mismatches++;
        end
        $display("covered %0d commands (%0d ticks) over %0d register settings",
                 items_sent, ticks_sent, settings_used);
        $display("checked %0d note events, %0d mismatches", events_checked, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[note_arpeggiator.f]
rtl/arp_pkg.sv
rtl/arp_modu.sv
rtl/arp_dp.sv
rtl/arp_ctrl.sv
rtl/note_arpeggiator.sv
test/tb_note_arpeggiator.sv
